// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL files (adtsf_rsp_buf includes them).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: cond");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: ante -> cons");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: ante => cons");

`endif

// ----- hw/rtl/adtsf_pkg.sv -----
package adtsf_pkg;

   // parser phase
   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   // configuration register indexes
   localparam logic [1:0] CSR_INIT_SEQ  = 2'd0;
   localparam logic [1:0] CSR_INIT_TS   = 2'd1;
   localparam logic [1:0] CSR_TS_STEP   = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_AU_HDR  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // ADTS / AU-header constants
   localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
   localparam logic [3:0]  SYNC_NIBBLE   = 4'hF;
   localparam logic [7:0]  AU_HDR_LEN_HI = 8'h00;
   localparam logic [7:0]  AU_HDR_LEN_LO = 8'h10;
   localparam logic [12:0] ADTS_HDR_LEN  = 13'd7;
   localparam logic [15:0] TS_STEP_RESET = 16'd1024;

   // header byte positions
   localparam logic [2:0] HIDX_NONE  = 3'd0;
   localparam logic [2:0] HIDX_SYNC2 = 3'd1;
   localparam logic [2:0] HIDX_LAST  = 3'd6;

   localparam int MAX_RESULTS = 4;
   localparam int CNT_W       = 3;

   // one result byte
   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] byte_kind;
      logic       frame_end;
      logic       run_last;
   } rsp_item_type;

   // all results caused by one request, with the fields they share
   typedef struct packed {
      logic [CNT_W-1:0]                 count;
      rsp_item_type [MAX_RESULTS-1:0]   items;
      logic [15:0]                      sequence_res;
      logic [31:0]                      timestamp;
      logic [1:0]                       profile;
      logic [3:0]                       rate_index;
      logic [2:0]                       channels;
   } burst_type;

endpackage

// ----- hw/rtl/adtsf_rsp_buf.sv -----
`include "assert_macros.svh"

// Holds the results of one request and hands them out one per cycle while the response is not stalled.
module adtsf_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  adtsf_pkg::burst_type  burst,
   output logic                  ready,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic [1:0]            rsp_byte_kind,
   output logic                  rsp_frame_end,
   output logic                  rsp_run_last,
   output logic [15:0]           rsp_sequence_res,
   output logic [31:0]           rsp_timestamp,
   output logic [1:0]            rsp_profile,
   output logic [3:0]            rsp_rate_index,
   output logic [2:0]            rsp_channels
);

   logic [adtsf_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   adtsf_pkg::burst_type        buf_ff, buf_in;
   logic                        rsp_accept;

   assign rsp_valid  = (cnt_ff != '0);
   assign rsp_accept = rsp_valid && !rsp_stall;
   // room for a new request once the last held result leaves
   assign ready = (cnt_ff == '0) ||
                  ((cnt_ff == adtsf_pkg::CNT_W'(1)) && !rsp_stall);

   // load a new burst or shift out the head entry
   always_comb begin
      cnt_in = cnt_ff;
      buf_in = buf_ff;
      if (load) begin
         cnt_in = burst.count;
         buf_in = burst;
      end else if (rsp_accept) begin
         cnt_in = cnt_ff - adtsf_pkg::CNT_W'(1);
         for (int k = 0; k < adtsf_pkg::MAX_RESULTS - 1; k++) begin
            buf_in.items[k] = buf_ff.items[k+1];
         end
         buf_in.items[adtsf_pkg::MAX_RESULTS-1] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   assign rsp_out_byte     = buf_ff.items[0].out_byte;
   assign rsp_byte_kind    = buf_ff.items[0].byte_kind;
   assign rsp_frame_end    = buf_ff.items[0].frame_end;
   assign rsp_run_last     = buf_ff.items[0].run_last;
   assign rsp_sequence_res = buf_ff.sequence_res;
   assign rsp_timestamp    = buf_ff.timestamp;
   assign rsp_profile      = buf_ff.profile;
   assign rsp_rate_index   = buf_ff.rate_index;
   assign rsp_channels     = buf_ff.channels;

   `ASSERT_ALWAYS(a_cnt_max, clock, reset, cnt_ff <= adtsf_pkg::CNT_W'(adtsf_pkg::MAX_RESULTS))
   `ASSERT_IMPLIES(a_load_ready, clock, reset, load, ready)
   `ASSERT_IMPLIES(a_last_tail, clock, reset, rsp_valid, rsp_run_last == (cnt_ff == adtsf_pkg::CNT_W'(1)))
   `ASSERT_NEXT(a_load_shows, clock, reset, load && (burst.count != '0), rsp_valid)

endmodule

// ----- hw/rtl/adts_to_rtp_au_framer.sv -----
// Channel   | Ports                          | Moves
// ----------+--------------------------------+-------------------------------
// request   | req_valid/req_stall, req_*     | one ADTS stream byte
// response  | rsp_valid/rsp_stall, rsp_*     | AU-header, payload or error byte
// config    | csr_write, csr_index, csr_data | register write, no wait
//
// A request is parsed in the cycle it is accepted; its results appear on the
// response port from the next cycle, one per cycle while rsp_stall is low.
// The seventh header byte makes four results unless the frame length is shorter
// than the header, so the request port stalls while the result buffer drains.
// Reset is synchronous: hunting for sync, counters at zero, step at 1024.
// A stalled response holds the buffer and, while it holds a result, the request port.
module adts_to_rtp_au_framer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_byte_kind,
   output logic        rsp_frame_end,
   output logic        rsp_run_last,
   output logic [15:0] rsp_sequence_res,
   output logic [31:0] rsp_timestamp,
   output logic [1:0]  rsp_profile,
   output logic [3:0]  rsp_rate_index,
   output logic [2:0]  rsp_channels,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   adtsf_pkg::phase_type phase_ff, phase_in;
   logic [2:0]           hidx_ff, hidx_in;
   logic [7:0]           hdr_ff [2:5];
   logic [12:0]          left_ff, left_in;
   logic [15:0]          seq_ff, seq_in;
   logic [31:0]          ts_ff, ts_in;
   logic [15:0]          step_ff, step_in;

   adtsf_pkg::burst_type burst;
   logic                 buf_ready;
   logic                 req_accept;
   logic                 advance;
   logic                 hdr_err;

   logic [12:0] frame_len;
   logic [12:0] plen;
   logic        sync_bad;
   logic        len_short;
   logic        plen_zero;
   logic        pay_last;

   assign req_stall  = !buf_ready;
   assign req_accept = req_valid && buf_ready;

   // header decode
   assign frame_len = {hdr_ff[3][1:0], hdr_ff[4], hdr_ff[5][7:5]};
   assign plen      = frame_len - adtsf_pkg::ADTS_HDR_LEN;
   assign sync_bad  = (req_data_byte[7:4] != adtsf_pkg::SYNC_NIBBLE);
   assign len_short = (frame_len < adtsf_pkg::ADTS_HDR_LEN);
   assign plen_zero = (plen == '0);
   assign pay_last  = (left_ff <= 13'd1);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         adtsf_pkg::PH_HUNT: begin
            if (req_data_byte == adtsf_pkg::SYNC_BYTE) phase_in = adtsf_pkg::PH_HEADER;
         end
         adtsf_pkg::PH_HEADER: begin
            if (hidx_ff == adtsf_pkg::HIDX_SYNC2) begin
               if (sync_bad) phase_in = adtsf_pkg::PH_HUNT;
            end else if (hidx_ff == adtsf_pkg::HIDX_LAST) begin
               if (len_short || plen_zero) phase_in = adtsf_pkg::PH_HUNT;
               else phase_in = adtsf_pkg::PH_PAYLOAD;
            end else if (hidx_ff == adtsf_pkg::HIDX_NONE || hidx_ff > adtsf_pkg::HIDX_LAST) begin
               phase_in = adtsf_pkg::PH_HUNT;
            end
         end
         adtsf_pkg::PH_PAYLOAD: begin
            if (pay_last) phase_in = adtsf_pkg::PH_HUNT;
         end
         default: phase_in = adtsf_pkg::PH_HUNT;
      endcase
   end

   // results, header index and payload count
   always_comb begin
      burst              = '0;
      burst.sequence_res = seq_ff;
      burst.timestamp    = ts_ff;
      hdr_err            = 1'b0;
      advance            = 1'b0;
      hidx_in            = hidx_ff;
      left_in            = left_ff;
      unique case (phase_ff)
         adtsf_pkg::PH_HUNT: begin
            if (req_data_byte == adtsf_pkg::SYNC_BYTE) hidx_in = adtsf_pkg::HIDX_SYNC2;
         end
         adtsf_pkg::PH_HEADER: begin
            if (hidx_ff == adtsf_pkg::HIDX_SYNC2 && sync_bad) begin
               hdr_err = 1'b1;
               hidx_in = adtsf_pkg::HIDX_NONE;
            end else if (hidx_ff == adtsf_pkg::HIDX_NONE || hidx_ff > adtsf_pkg::HIDX_LAST) begin
               hidx_in = adtsf_pkg::HIDX_NONE;
            end else if (hidx_ff < adtsf_pkg::HIDX_LAST) begin
               hidx_in = hidx_ff + 3'd1;
            end else begin
               hidx_in = adtsf_pkg::HIDX_NONE;
               if (len_short) begin
                  hdr_err = 1'b1;
               end else begin
                  // AU-header section: length in bits, then AU size << 3
                  burst.count    = adtsf_pkg::CNT_W'(4);
                  burst.items[0] = '{adtsf_pkg::AU_HDR_LEN_HI, adtsf_pkg::KIND_AU_HDR,
                                     1'b0, 1'b0};
                  burst.items[1] = '{adtsf_pkg::AU_HDR_LEN_LO, adtsf_pkg::KIND_AU_HDR,
                                     1'b0, 1'b0};
                  burst.items[2] = '{plen[12:5], adtsf_pkg::KIND_AU_HDR, 1'b0, 1'b0};
                  burst.items[3] = '{{plen[4:0], 3'b000}, adtsf_pkg::KIND_AU_HDR,
                                     plen_zero, 1'b1};
                  advance        = plen_zero;
                  if (!plen_zero) left_in = plen;
               end
            end
         end
         adtsf_pkg::PH_PAYLOAD: begin
            burst.count    = adtsf_pkg::CNT_W'(1);
            burst.items[0] = '{req_data_byte, adtsf_pkg::KIND_PAYLOAD, pay_last, 1'b1};
            if (pay_last) begin
               left_in = '0;
               advance = 1'b1;
            end else begin
               left_in = left_ff - 13'd1;
            end
         end
         default: hidx_in = adtsf_pkg::HIDX_NONE;
      endcase

      if (hdr_err) begin
         burst.count    = adtsf_pkg::CNT_W'(1);
         burst.items[0] = '{req_data_byte, adtsf_pkg::KIND_ERROR, 1'b0, 1'b1};
      end else begin
         burst.profile    = hdr_ff[2][7:6];
         burst.rate_index = hdr_ff[2][5:2];
         burst.channels   = {hdr_ff[2][0], hdr_ff[3][7:6]};
      end
   end

   // frame counters and register writes
   always_comb begin
      seq_in  = seq_ff;
      ts_in   = ts_ff;
      step_in = step_ff;
      if (req_accept && advance) begin
         seq_in = seq_ff + 16'd1;
         ts_in  = ts_ff + {16'd0, step_ff};
      end
      if (csr_write) begin
         unique case (csr_index)
            adtsf_pkg::CSR_INIT_SEQ: seq_in  = csr_data[15:0];
            adtsf_pkg::CSR_INIT_TS:  ts_in   = csr_data;
            adtsf_pkg::CSR_TS_STEP:  step_in = csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= adtsf_pkg::PH_HUNT;
         hidx_ff  <= adtsf_pkg::HIDX_NONE;
         left_ff  <= '0;
         seq_ff   <= '0;
         ts_ff    <= '0;
         step_ff  <= adtsf_pkg::TS_STEP_RESET;
      end else begin
         if (req_accept) begin
            phase_ff <= phase_in;
            hidx_ff  <= hidx_in;
            left_ff  <= left_in;
         end
         seq_ff  <= seq_in;
         ts_ff   <= ts_in;
         step_ff <= step_in;
      end
   end

   // header bytes that carry the parsed fields and the frame length
   always_ff @(posedge clock) begin
      for (int k = 2; k <= 5; k++) begin
         if (req_accept && phase_ff == adtsf_pkg::PH_HEADER && hidx_ff == 3'(k)) begin
            hdr_ff[k] <= req_data_byte;
         end
      end
   end

   adtsf_rsp_buf u_rsp_buf (
      .clock            (clock),
      .reset            (reset),
      .load             (req_accept),
      .burst            (burst),
      .ready            (buf_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_kind    (rsp_byte_kind),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_run_last     (rsp_run_last),
      .rsp_sequence_res (rsp_sequence_res),
      .rsp_timestamp    (rsp_timestamp),
      .rsp_profile      (rsp_profile),
      .rsp_rate_index   (rsp_rate_index),
      .rsp_channels     (rsp_channels)
   );

endmodule

// ----- verif/tb.sv -----
module tb;

   // index past the last register, writes to it must be dropped
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   // cycles to wait after the last expected byte before touching registers
   localparam int IDLE_TAIL = 8;
   // slowest run: ~1.5k requests, each after a random gap, and up to four
   // results per request, each after a random stall; taken several times over
   localparam int CYCLE_LIMIT = 600_000;

   // one response byte with every field the block reports
   typedef struct packed {
      logic [7:0]  out_byte;
      logic [1:0]  byte_kind;
      logic        frame_end;
      logic        run_last;
      logic [15:0] sequence_res;
      logic [31:0] timestamp;
      logic [1:0]  profile;
      logic [3:0]  rate_index;
      logic [2:0]  channels;
   } au_byte_type;

   // tracks the parser and RTP counters, holds the AU bytes still owed
   class au_tracker;
      adtsf_pkg::phase_type phase;
      logic [2:0]  hdr_pos;
      logic [7:0]  hdr [0:6];
      logic [12:0] payload_left;
      logic [15:0] seq_count;
      logic [31:0] ts_count;
      logic [15:0] ts_step;
      au_byte_type au_bytes_due[$];
      int          mismatches;

      function new();
         phase        = adtsf_pkg::PH_HUNT;
         hdr_pos      = adtsf_pkg::HIDX_NONE;
         payload_left = '0;
         seq_count    = '0;
         ts_count     = '0;
         ts_step      = adtsf_pkg::TS_STEP_RESET;
         mismatches   = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] data);
         case (idx)
            adtsf_pkg::CSR_INIT_SEQ: seq_count = data[15:0];
            adtsf_pkg::CSR_INIT_TS:  ts_count  = data;
            adtsf_pkg::CSR_TS_STEP:  ts_step   = data[15:0];
            default: ;
         endcase
      endfunction

      function void owe_byte(logic [7:0] b, logic [1:0] kind, logic fend, logic last,
                             bit parsed);
         au_byte_type r;
         r.out_byte     = b;
         r.byte_kind    = kind;
         r.frame_end    = fend;
         r.run_last     = last;
         r.sequence_res = seq_count;
         r.timestamp    = ts_count;
         if (parsed) begin
            r.profile    = hdr[2][7:6];
            r.rate_index = hdr[2][5:2];
            r.channels   = {hdr[2][0], hdr[3][7:6]};
         end else begin
            r.profile    = '0;
            r.rate_index = '0;
            r.channels   = '0;
         end
         au_bytes_due.push_back(r);
      endfunction

      function void close_frame();
         seq_count = seq_count + 16'd1;
         ts_count  = ts_count + {16'd0, ts_step};
         phase     = adtsf_pkg::PH_HUNT;
      endfunction

      // returns 0 when the byte is dropped while hunting
      function bit take_byte(logic [7:0] b);
         logic [12:0] frame_len;
         logic [12:0] plen;
         take_byte = 1'b1;
         case (phase)
            adtsf_pkg::PH_HUNT: begin
               if (b == adtsf_pkg::SYNC_BYTE) begin
                  hdr[0]  = b;
                  hdr_pos = adtsf_pkg::HIDX_SYNC2;
                  phase   = adtsf_pkg::PH_HEADER;
               end else begin
                  take_byte = 1'b0;
               end
            end
            adtsf_pkg::PH_HEADER: begin
               hdr[hdr_pos] = b;
               if (hdr_pos == adtsf_pkg::HIDX_SYNC2 && b[7:4] != adtsf_pkg::SYNC_NIBBLE) begin
                  owe_byte(b, adtsf_pkg::KIND_ERROR, 1'b0, 1'b1, 1'b0);
                  phase   = adtsf_pkg::PH_HUNT;
                  hdr_pos = adtsf_pkg::HIDX_NONE;
               end else if (hdr_pos < adtsf_pkg::HIDX_LAST) begin
                  hdr_pos = hdr_pos + 3'd1;
               end else begin
                  frame_len = {hdr[3][1:0], hdr[4], hdr[5][7:5]};
                  hdr_pos   = adtsf_pkg::HIDX_NONE;
                  if (frame_len < adtsf_pkg::ADTS_HDR_LEN) begin
                     owe_byte(b, adtsf_pkg::KIND_ERROR, 1'b0, 1'b1, 1'b0);
                     phase = adtsf_pkg::PH_HUNT;
                  end else begin
                     // AU-header section: length 16 bits, then size << 3
                     plen = frame_len - adtsf_pkg::ADTS_HDR_LEN;
                     owe_byte(adtsf_pkg::AU_HDR_LEN_HI, adtsf_pkg::KIND_AU_HDR,
                              1'b0, 1'b0, 1'b1);
                     owe_byte(adtsf_pkg::AU_HDR_LEN_LO, adtsf_pkg::KIND_AU_HDR,
                              1'b0, 1'b0, 1'b1);
                     owe_byte(plen[12:5], adtsf_pkg::KIND_AU_HDR, 1'b0, 1'b0, 1'b1);
                     owe_byte({plen[4:0], 3'b000}, adtsf_pkg::KIND_AU_HDR,
                              plen == 13'd0, 1'b1, 1'b1);
                     if (plen == 13'd0) begin
                        close_frame();
                     end else begin
                        payload_left = plen;
                        phase        = adtsf_pkg::PH_PAYLOAD;
                     end
                  end
               end
            end
            adtsf_pkg::PH_PAYLOAD: begin
               owe_byte(b, adtsf_pkg::KIND_PAYLOAD, payload_left <= 13'd1, 1'b1, 1'b1);
               if (payload_left <= 13'd1) begin
                  payload_left = '0;
                  close_frame();
               end else begin
                  payload_left = payload_left - 13'd1;
               end
            end
            default: begin
               phase   = adtsf_pkg::PH_HUNT;
               hdr_pos = adtsf_pkg::HIDX_NONE;
            end
         endcase
      endfunction

      function void flag(string what, au_byte_type want, au_byte_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("%s: exp byte=%h kind=%0d end=%b last=%b seq=%h ts=%h p=%0d r=%0d c=%0d",
                     what, want.out_byte, want.byte_kind, want.frame_end, want.run_last,
                     want.sequence_res, want.timestamp, want.profile, want.rate_index,
                     want.channels);
         if (mismatches <= 10)
            $display("   got byte=%h kind=%0d end=%b last=%b seq=%h ts=%h p=%0d r=%0d c=%0d",
                     got.out_byte, got.byte_kind, got.frame_end, got.run_last,
                     got.sequence_res, got.timestamp, got.profile, got.rate_index,
                     got.channels);
      endfunction

      function void match_result(au_byte_type got);
         au_byte_type want;
         if (au_bytes_due.size() == 0) begin
            flag("unexpected byte", '0, got);
            return;
         end
         want = au_bytes_due.pop_front();
         if (got.out_byte !== want.out_byte || got.byte_kind !== want.byte_kind ||
             got.frame_end !== want.frame_end || got.run_last !== want.run_last ||
             got.sequence_res !== want.sequence_res || got.timestamp !== want.timestamp ||
             got.profile !== want.profile || got.rate_index !== want.rate_index ||
             got.channels !== want.channels)
            flag("byte mismatch", want, got);
      endfunction

      function void close_run();
         if (au_bytes_due.size() != 0) begin
            $display("%0d AU bytes never arrived", au_bytes_due.size());
            mismatches += au_bytes_due.size();
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic [1:0]  rsp_byte_kind;
   logic        rsp_frame_end;
   logic        rsp_run_last;
   logic [15:0] rsp_sequence_res;
   logic [31:0] rsp_timestamp;
   logic [1:0]  rsp_profile;
   logic [3:0]  rsp_rate_index;
   logic [2:0]  rsp_channels;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   au_tracker tracker;
   bit        no_idle = 1'b0;
   int        live_bytes = 0;
   int        rsp_hold = 0;
   int        cycle_count = 0;

   adts_to_rtp_au_framer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_kind    (rsp_byte_kind),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_run_last     (rsp_run_last),
      .rsp_sequence_res (rsp_sequence_res),
      .rsp_timestamp    (rsp_timestamp),
      .rsp_profile      (rsp_profile),
      .rsp_rate_index   (rsp_rate_index),
      .rsp_channels     (rsp_channels),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // response side: check each accepted byte, then stall a random while
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_valid && !rsp_stall) begin
         tracker.match_result({rsp_out_byte, rsp_byte_kind, rsp_frame_end, rsp_run_last,
                               rsp_sequence_res, rsp_timestamp, rsp_profile,
                               rsp_rate_index, rsp_channels});
         rsp_hold = no_idle ? 0 : $urandom_range(0, 17);
         rsp_stall <= (rsp_hold != 0);
      end else if (rsp_hold != 0) begin
         rsp_hold--;
         rsp_stall <= (rsp_hold != 0);
      end
   end

   // one request; valid stays high when the next gap is zero
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      if (tracker.take_byte(b))
         live_bytes++;
   endtask

   // ADTS frame: header carrying frame_len and b2, then random payload
   task automatic send_adts(input logic [12:0] frame_len, input logic [7:0] b2);
      send_byte(adtsf_pkg::SYNC_BYTE);
      send_byte({adtsf_pkg::SYNC_NIBBLE, 4'($urandom)});
      send_byte(b2);
      send_byte({6'($urandom), frame_len[12:11]});
      send_byte(frame_len[10:3]);
      send_byte({frame_len[2:0], 5'($urandom)});
      send_byte(8'($urandom));
      if (frame_len > adtsf_pkg::ADTS_HDR_LEN)
         repeat (frame_len - adtsf_pkg::ADTS_HDR_LEN) send_byte(8'($urandom));
   endtask

   task automatic bad_sync();
      send_byte(adtsf_pkg::SYNC_BYTE);
      send_byte({4'($urandom_range(0, 14)), 4'($urandom)});
   endtask

   // one register write, then the write strobe is dropped before anything else
   task automatic write_csr(input logic [1:0] idx, input logic [31:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      tracker.write_reg(idx, data);
      @(posedge clock);
   endtask

   // drain all owed bytes, then let the parser go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.au_bytes_due.size() != 0) @(posedge clock);
      repeat (IDLE_TAIL) @(posedge clock);
   endtask

   // mostly well-formed frames, some broken syncs, short lengths and noise
   task automatic random_frames(input int target);
      int start;
      int pick;
      start = live_bytes;
      while (live_bytes - start < target) begin
         pick    = $urandom_range(0, 99);
         no_idle = ($urandom_range(0, 4) == 0);
         if (pick < 6)
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 254)));
         else if (pick < 14)
            bad_sync();
         else if (pick < 22)
            send_adts(13'($urandom_range(0, 6)), 8'($urandom));
         else if (pick < 30)
            send_adts(adtsf_pkg::ADTS_HDR_LEN, 8'($urandom));
         else if (pick < 88)
            send_adts(13'($urandom_range(8, 40)), 8'($urandom));
         else
            send_adts(13'($urandom_range(41, 300)), 8'($urandom));
      end
      no_idle = 1'b0;
   endtask

   initial begin
      tracker = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: dropped noise, bad sync, short length, header-only, one payload byte
      send_byte(8'h00);
      send_byte(adtsf_pkg::SYNC_BYTE);
      send_byte(8'h0F);
      send_adts(13'd6, 8'hFF);
      send_adts(adtsf_pkg::ADTS_HDR_LEN, 8'h00);
      send_adts(13'd8, 8'h5A);
      settle();

      // counters at the top so they wrap on the first frames
      write_csr(adtsf_pkg::CSR_INIT_SEQ, 32'h0000_FFFF);
      write_csr(adtsf_pkg::CSR_INIT_TS, 32'hFFFF_FFFF);
      write_csr(adtsf_pkg::CSR_TS_STEP, 32'h0000_FFFF);
      random_frames(32);
      settle();

      // zero step, plus a write to the unused index
      write_csr(adtsf_pkg::CSR_INIT_SEQ, 32'd0);
      write_csr(adtsf_pkg::CSR_INIT_TS, 32'd0);
      write_csr(adtsf_pkg::CSR_TS_STEP, 32'd0);
      write_csr(CSR_UNUSED, $urandom);
      random_frames(32);
      settle();

      // random setting
      write_csr(adtsf_pkg::CSR_INIT_SEQ, $urandom);
      write_csr(adtsf_pkg::CSR_INIT_TS, $urandom);
      write_csr(adtsf_pkg::CSR_TS_STEP, $urandom);
      random_frames(32);
      settle();

      write_csr(adtsf_pkg::CSR_INIT_SEQ, 32'h0000_FFFE);
      write_csr(adtsf_pkg::CSR_INIT_TS, 32'hFFFF_F000);
      write_csr(adtsf_pkg::CSR_TS_STEP, {16'd0, adtsf_pkg::TS_STEP_RESET});
      random_frames(32);
      settle();

      write_csr(adtsf_pkg::CSR_INIT_SEQ, $urandom);
      write_csr(adtsf_pkg::CSR_INIT_TS, $urandom);
      write_csr(adtsf_pkg::CSR_TS_STEP, $urandom);
      random_frames(32);
      settle();

      tracker.close_run();
      if (tracker.mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
